// ----- rtl/core/lsced_pkg.sv -----
// Shared constants and codes for the line scan colour edge detector.
`default_nettype none

package lsced_pkg;

  // Default coordinate width (columns and rows).
  localparam int COORD_WIDTH_DEFAULT = 12;

  // Fixed field widths.
  localparam int HEIGHT_WIDTH    = 13;
  localparam int THRESH_WIDTH    = 18;
  localparam int CFG_DATA_WIDTH  = 18;
  localparam int CFG_INDEX_WIDTH = 1;
  localparam int RGB_WIDTH       = 8;
  localparam int GAP_WIDTH       = 8;

  // Register reset values.
  localparam logic [HEIGHT_WIDTH-1:0] HEIGHT_RESET = 13'd480;
  localparam logic [THRESH_WIDTH-1:0] THRESH_RESET = 18'd10000;
  localparam logic [GAP_WIDTH-1:0]    GAP_RESET    = 8'd1;

  // Configuration register indexes.
  typedef enum logic [CFG_INDEX_WIDTH-1:0] {
    REG_IMAGE_HEIGHT       = 1'b0,
    REG_DISTANCE_THRESHOLD = 1'b1
  } cfg_reg_t;

  // Request kinds.
  typedef enum logic {
    KIND_START = 1'b0,
    KIND_PIXEL = 1'b1
  } item_kind_t;

endpackage

`default_nettype wire

// ----- rtl/core/lsced_scan.sv -----
// Line walk state, colour distance test and feature point arithmetic.
`default_nettype none

module lsced_scan
  import lsced_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       step,
  input  wire logic                       kind,
  input  wire logic [COORD_WIDTH-1:0]     start_x,
  input  wire logic [COORD_WIDTH-1:0]     start_y,
  input  wire logic [COORD_WIDTH-1:0]     end_x,
  input  wire logic [COORD_WIDTH-1:0]     end_y,
  input  wire logic [GAP_WIDTH-1:0]       gap_after_feature,
  input  wire logic [RGB_WIDTH-1:0]       red,
  input  wire logic [RGB_WIDTH-1:0]       green,
  input  wire logic [RGB_WIDTH-1:0]       blue,
  output logic [COORD_WIDTH-1:0]          next_x,
  output logic [COORD_WIDTH-1:0]          next_y,
  output logic                            line_done,
  output logic                            feature_found,
  output logic [COORD_WIDTH:0]            feature_x_half,
  output logic [COORD_WIDTH:0]            feature_y_half
);

  localparam int CW   = COORD_WIDTH;
  localparam int EW   = CW + 2;
  localparam int YW   = ((HEIGHT_WIDTH + 1 > CW + 1) ? HEIGHT_WIDTH + 1 : CW + 1) + 1;
  localparam int YWM1 = YW - 1;
  localparam int HW   = CW + 1;
  localparam logic [HW-1:0]   HalfMax     = {HW{1'b1}};
  localparam logic [YWM1-1:0] HalfMaxWide = YWM1'(HalfMax);

  // Configuration registers
  logic [HEIGHT_WIDTH-1:0] image_height;
  logic [THRESH_WIDTH-1:0] distance_threshold;

  // Walk state
  logic                   active,          active_next;
  logic                   steep_flag,      steep_flag_next;
  logic [CW-1:0]          walk_major,      walk_major_next;
  logic [CW-1:0]          walk_major_end,  walk_major_end_next;
  logic [CW-1:0]          walk_minor,      walk_minor_next;
  logic                   minor_step_down, minor_step_down_next;
  logic signed [EW-1:0]   error_term,      error_term_next;
  logic [CW-1:0]          major_delta,     major_delta_next;
  logic [CW-1:0]          minor_delta,     minor_delta_next;
  logic [GAP_WIDTH-1:0]   skip_count,      skip_count_next;
  logic [GAP_WIDTH-1:0]   gap_value,       gap_value_next;
  logic                   have_previous,   have_previous_next;
  logic [3*RGB_WIDTH-1:0] previous_rgb,    previous_rgb_next;
  logic [CW-1:0]          previous_x,      previous_x_next;
  logic [CW-1:0]          previous_y,      previous_y_next;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      image_height       <= HEIGHT_RESET;
      distance_threshold <= THRESH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_IMAGE_HEIGHT:       image_height       <= cfg_data[HEIGHT_WIDTH-1:0];
        REG_DISTANCE_THRESHOLD: distance_threshold <= cfg_data[THRESH_WIDTH-1:0];
        default: ;
      endcase
    end
  end

  // Current pixel address
  logic [CW-1:0] cur_x, cur_y;
  assign cur_x = steep_flag ? walk_minor : walk_major;
  assign cur_y = steep_flag ? walk_major : walk_minor;

  // Line set-up: steepness, endpoint ordering, deltas
  logic [CW-1:0] span_x, span_y;
  logic          start_steep;
  logic [CW-1:0] p_a0, p_b0, p_a1, p_b1;
  logic [CW-1:0] o_a0, o_b0, o_a1, o_b1;

  always_comb begin
    span_x      = (end_x > start_x) ? end_x - start_x : start_x - end_x;
    span_y      = (end_y > start_y) ? end_y - start_y : start_y - end_y;
    start_steep = span_y > span_x;
    p_a0 = start_steep ? start_y : start_x;
    p_b0 = start_steep ? start_x : start_y;
    p_a1 = start_steep ? end_y   : end_x;
    p_b1 = start_steep ? end_x   : end_y;
    if (p_a0 > p_a1) begin
      o_a0 = p_a1; o_b0 = p_b1; o_a1 = p_a0; o_b1 = p_b0;
    end else begin
      o_a0 = p_a0; o_b0 = p_b0; o_a1 = p_a1; o_b1 = p_b1;
    end
  end

  // Squared RGB distance to the previous pixel
  logic [RGB_WIDTH-1:0]   d_r, d_g, d_b;
  logic [2*RGB_WIDTH-1:0] sq_r, sq_g, sq_b;
  logic [THRESH_WIDTH-1:0] colour_dist;

  always_comb begin
    d_r = (red   > previous_rgb[3*RGB_WIDTH-1:2*RGB_WIDTH])
        ? red - previous_rgb[3*RGB_WIDTH-1:2*RGB_WIDTH]
        : previous_rgb[3*RGB_WIDTH-1:2*RGB_WIDTH] - red;
    d_g = (green > previous_rgb[2*RGB_WIDTH-1:RGB_WIDTH])
        ? green - previous_rgb[2*RGB_WIDTH-1:RGB_WIDTH]
        : previous_rgb[2*RGB_WIDTH-1:RGB_WIDTH] - green;
    d_b = (blue  > previous_rgb[RGB_WIDTH-1:0])
        ? blue - previous_rgb[RGB_WIDTH-1:0]
        : previous_rgb[RGB_WIDTH-1:0] - blue;
    sq_r = d_r * d_r;
    sq_g = d_g * d_g;
    sq_b = d_b * d_b;
    colour_dist = THRESH_WIDTH'(sq_r) + THRESH_WIDTH'(sq_g) + THRESH_WIDTH'(sq_b);
  end

  // Feature point in half pixels, y flipped and clamped
  logic [YW-1:0] y_raw;
  logic [HW-1:0] y_half, x_half;
  logic          is_pixel, pixel_step, feature_hit;

  always_comb begin
    x_half = HW'(previous_x) + HW'(cur_x) + HW'(1);
    y_raw  = YW'({image_height, 1'b0}) - YW'(1) - YW'(previous_y) - YW'(cur_y);
    if (y_raw[YW-1]) begin
      y_half = '0;
    end else if (y_raw[YW-2:0] > HalfMaxWide) begin
      y_half = HalfMax;
    end else begin
      y_half = y_raw[HW-1:0];
    end
    is_pixel    = (item_kind_t'(kind) == KIND_PIXEL);
    pixel_step  = is_pixel && active;
    feature_hit = pixel_step && have_previous && (skip_count == '0)
                  && (colour_dist > distance_threshold);
  end

  // Next walk state
  logic signed [EW-1:0] err_sub;
  logic [GAP_WIDTH-1:0] skip_base;

  always_comb begin
    active_next          = active;
    steep_flag_next      = steep_flag;
    walk_major_next      = walk_major;
    walk_major_end_next  = walk_major_end;
    walk_minor_next      = walk_minor;
    minor_step_down_next = minor_step_down;
    error_term_next      = error_term;
    major_delta_next     = major_delta;
    minor_delta_next     = minor_delta;
    skip_count_next      = skip_count;
    gap_value_next       = gap_value;
    have_previous_next   = have_previous;
    previous_rgb_next    = previous_rgb;
    previous_x_next      = previous_x;
    previous_y_next      = previous_y;
    err_sub              = error_term - $signed(EW'(minor_delta));
    skip_base            = feature_hit ? gap_value : skip_count;

    if (!is_pixel) begin
      // new line, abandons any line in progress
      steep_flag_next      = start_steep;
      major_delta_next     = o_a1 - o_a0;
      minor_delta_next     = (o_b1 > o_b0) ? o_b1 - o_b0 : o_b0 - o_b1;
      error_term_next      = $signed(EW'((o_a1 - o_a0) >> 1));
      minor_step_down_next = !(o_b0 < o_b1);
      walk_major_next      = o_a0;
      walk_major_end_next  = o_a1;
      walk_minor_next      = o_b0;
      gap_value_next       = (gap_after_feature == '0) ? GAP_RESET : gap_after_feature;
      skip_count_next      = '0;
      have_previous_next   = 1'b0;
      active_next          = o_a0 < o_a1;
    end else if (active) begin
      skip_count_next = (skip_base != '0) ? skip_base - GAP_WIDTH'(1) : skip_base;
      if (err_sub < 0) begin
        walk_minor_next = minor_step_down ? walk_minor - CW'(1) : walk_minor + CW'(1);
        error_term_next = err_sub + $signed(EW'(major_delta));
      end else begin
        error_term_next = err_sub;
      end
      walk_major_next    = walk_major + CW'(1);
      have_previous_next = 1'b1;
      previous_rgb_next  = {red, green, blue};
      previous_x_next    = cur_x;
      previous_y_next    = cur_y;
      active_next        = (walk_major + CW'(1)) < walk_major_end;
    end
  end

  // Result: address after the step, feature if one was found
  always_comb begin
    line_done      = !active_next;
    next_x         = active_next ? (steep_flag_next ? walk_minor_next : walk_major_next) : '0;
    next_y         = active_next ? (steep_flag_next ? walk_major_next : walk_minor_next) : '0;
    feature_found  = feature_hit;
    feature_x_half = feature_hit ? x_half : '0;
    feature_y_half = feature_hit ? y_half : '0;
  end

  // State update on each request handed on
  always_ff @(posedge clk) begin
    if (rst) begin
      active          <= 1'b0;
      steep_flag      <= 1'b0;
      walk_major      <= '0;
      walk_major_end  <= '0;
      walk_minor      <= '0;
      minor_step_down <= 1'b0;
      error_term      <= '0;
      major_delta     <= '0;
      minor_delta     <= '0;
      skip_count      <= '0;
      gap_value       <= GAP_RESET;
      have_previous   <= 1'b0;
      previous_rgb    <= '0;
      previous_x      <= '0;
      previous_y      <= '0;
    end else if (step) begin
      active          <= active_next;
      steep_flag      <= steep_flag_next;
      walk_major      <= walk_major_next;
      walk_major_end  <= walk_major_end_next;
      walk_minor      <= walk_minor_next;
      minor_step_down <= minor_step_down_next;
      error_term      <= error_term_next;
      major_delta     <= major_delta_next;
      minor_delta     <= minor_delta_next;
      skip_count      <= skip_count_next;
      gap_value       <= gap_value_next;
      have_previous   <= have_previous_next;
      previous_rgb    <= previous_rgb_next;
      previous_x      <= previous_x_next;
      previous_y      <= previous_y_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/line_scan_color_edge_detector_unit.sv -----
// Line scan colour edge detector: request and result registers around the walk core.
//
// Usage: send a start request (kind 0) with the line endpoints and the gap; the
// result gives the first pixel address to fetch, or line_done for a line with no
// pixels. Then send one pixel request (kind 1) per returned address carrying its
// RGB value; each result flags a feature at the midpoint of the previous and the
// current pixel and gives the next address, until line_done. Pixel requests with
// no line active return line_done and change nothing.
// Both channels use valid/stall: a request is taken when valid is high and stall
// is low. A request passes through the request register, then the result
// register; one request per cycle is sustained while the receiver does not stall,
// as the walk step, the three 8x8 squares and the threshold compare all settle in
// the single stage between the two registers.
// When the receiver stalls, the result holds and the request register still
// accepts one more request; item_stall rises only when both are full.
// Reset (rst, synchronous) empties both registers, clears the walk and restores
// image_height 480 and distance_threshold 10000. Configuration writes are taken
// in the cycle of cfg_write and must only happen while the block is idle.
`default_nettype none

module line_scan_color_edge_detector_unit
  import lsced_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_write,
  input  wire logic [CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [CFG_DATA_WIDTH-1:0]  cfg_data,
  input  wire logic                       item_valid,
  output logic                            item_stall,
  input  wire logic                       kind,
  input  wire logic [COORD_WIDTH-1:0]     start_x,
  input  wire logic [COORD_WIDTH-1:0]     start_y,
  input  wire logic [COORD_WIDTH-1:0]     end_x,
  input  wire logic [COORD_WIDTH-1:0]     end_y,
  input  wire logic [GAP_WIDTH-1:0]       gap_after_feature,
  input  wire logic [RGB_WIDTH-1:0]       red,
  input  wire logic [RGB_WIDTH-1:0]       green,
  input  wire logic [RGB_WIDTH-1:0]       blue,
  output logic                            result_valid,
  input  wire logic                       result_stall,
  output logic [COORD_WIDTH-1:0]          next_x,
  output logic [COORD_WIDTH-1:0]          next_y,
  output logic                            line_done,
  output logic                            feature_found,
  output logic [COORD_WIDTH:0]            feature_x_half,
  output logic [COORD_WIDTH:0]            feature_y_half
);

  localparam int CW = COORD_WIDTH;

  // Request register
  logic                 req_valid, req_valid_next;
  logic                 req_kind;
  logic [CW-1:0]        req_start_x, req_start_y, req_end_x, req_end_y;
  logic [GAP_WIDTH-1:0] req_gap;
  logic [RGB_WIDTH-1:0] req_red, req_green, req_blue;

  // Result register
  logic                 res_valid_next;
  logic                 advance, take;

  // Combinational result from the core
  logic [CW-1:0] c_next_x, c_next_y;
  logic          c_line_done, c_feature_found;
  logic [CW:0]   c_feature_x_half, c_feature_y_half;

  // Handshake
  assign advance    = !result_valid || !result_stall;
  assign item_stall = req_valid && !advance;
  assign take       = item_valid && !item_stall;

  always_comb begin
    req_valid_next = req_valid;
    if (take) begin
      req_valid_next = 1'b1;
    end else if (advance) begin
      req_valid_next = 1'b0;
    end
    res_valid_next = result_valid;
    if (req_valid && advance) begin
      res_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      res_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid    <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      req_valid    <= req_valid_next;
      result_valid <= res_valid_next;
    end
  end

  // Request payload capture
  always_ff @(posedge clk) begin
    if (take) begin
      req_kind    <= kind;
      req_start_x <= start_x;
      req_start_y <= start_y;
      req_end_x   <= end_x;
      req_end_y   <= end_y;
      req_gap     <= gap_after_feature;
      req_red     <= red;
      req_green   <= green;
      req_blue    <= blue;
    end
  end

  // Walk and colour core
  lsced_scan #(
    .COORD_WIDTH(CW)
  ) u_scan (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .step              (req_valid && advance),
    .kind              (req_kind),
    .start_x           (req_start_x),
    .start_y           (req_start_y),
    .end_x             (req_end_x),
    .end_y             (req_end_y),
    .gap_after_feature (req_gap),
    .red               (req_red),
    .green             (req_green),
    .blue              (req_blue),
    .next_x            (c_next_x),
    .next_y            (c_next_y),
    .line_done         (c_line_done),
    .feature_found     (c_feature_found),
    .feature_x_half    (c_feature_x_half),
    .feature_y_half    (c_feature_y_half)
  );

  // Result payload capture
  always_ff @(posedge clk) begin
    if (req_valid && advance) begin
      next_x         <= c_next_x;
      next_y         <= c_next_y;
      line_done      <= c_line_done;
      feature_found  <= c_feature_found;
      feature_x_half <= c_feature_x_half;
      feature_y_half <= c_feature_y_half;
    end
  end

  // Checks
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> (req_valid && result_valid && result_stall))
    else $error("request side stalled with room in the pipeline");

  a_done_has_no_address: assert property (@(posedge clk) disable iff (rst)
    (result_valid && line_done) |-> (next_x == '0 && next_y == '0))
    else $error("finished line reports a fetch address");

  a_no_feature_is_zero: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !feature_found) |->
      (feature_x_half == '0 && feature_y_half == '0))
    else $error("feature coordinates set without a feature");

  a_empty_after_reset: assert property (@(posedge clk)
    rst |=> (!result_valid && !req_valid))
    else $error("pipeline not empty after reset");

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
// Self-checking testbench for the line scan colour edge detector unit.
`timescale 1ns / 100ps

module testbench;
  import lsced_pkg::*;

  localparam int CW = COORD_WIDTH_DEFAULT;
  localparam int HALF_TOP = (1 << (CW + 1)) - 1;

  // One request and one result as they cross the ports
  typedef struct packed {
    item_kind_t       kind;
    logic [CW-1:0]    sx;
    logic [CW-1:0]    sy;
    logic [CW-1:0]    ex;
    logic [CW-1:0]    ey;
    logic [7:0]       gap;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } scan_req_t;

  typedef struct packed {
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic          done;
    logic          feat;
    logic [CW:0]   fxh;
    logic [CW:0]   fyh;
  } scan_res_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  cfg_reg_t                   cfg_index = REG_IMAGE_HEIGHT;
  logic [CFG_DATA_WIDTH-1:0]  cfg_data = '0;
  logic                       item_valid = 1'b0;
  logic                       item_stall;
  item_kind_t                 kind = KIND_START;
  logic [CW-1:0]              start_x = '0;
  logic [CW-1:0]              start_y = '0;
  logic [CW-1:0]              end_x = '0;
  logic [CW-1:0]              end_y = '0;
  logic [GAP_WIDTH-1:0]       gap_after_feature = '0;
  logic [RGB_WIDTH-1:0]       red = '0;
  logic [RGB_WIDTH-1:0]       green = '0;
  logic [RGB_WIDTH-1:0]       blue = '0;
  logic                       result_valid;
  logic                       result_stall = 1'b0;
  logic [CW-1:0]              next_x;
  logic [CW-1:0]              next_y;
  logic                       line_done;
  logic                       feature_found;
  logic [CW:0]                feature_x_half;
  logic [CW:0]                feature_y_half;

  line_scan_color_edge_detector_unit u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .item_valid(item_valid), .item_stall(item_stall),
    .kind(kind), .start_x(start_x), .start_y(start_y),
    .end_x(end_x), .end_y(end_y), .gap_after_feature(gap_after_feature),
    .red(red), .green(green), .blue(blue),
    .result_valid(result_valid), .result_stall(result_stall),
    .next_x(next_x), .next_y(next_y), .line_done(line_done),
    .feature_found(feature_found),
    .feature_x_half(feature_x_half), .feature_y_half(feature_y_half)
  );

  always #5 clk = ~clk;

  scan_req_t   pending_reqs[$];
  scan_res_t   due_results[$];
  int unsigned faults = 0;
  bit          calm = 1'b0;

  // Predictor copy of the registers and the walk
  logic [12:0]   cfg_height = 13'd480;
  logic [17:0]   cfg_thresh = 18'd10000;
  bit            on_line = 1'b0;
  bit            steep = 1'b0;
  logic [CW-1:0] maj = '0;
  logic [CW-1:0] maj_end = '0;
  logic [CW-1:0] minr = '0;
  bit            minr_down = 1'b0;
  int            err = 0;
  logic [CW-1:0] d_maj = '0;
  logic [CW-1:0] d_min = '0;
  logic [7:0]    skip_left = '0;
  logic [7:0]    gap_len = 8'd1;
  bit            seen_prev = 1'b0;
  logic [23:0]   prev_rgb = '0;
  logic [CW-1:0] prev_x = '0;
  logic [CW-1:0] prev_y = '0;

  // Colour state of the stimulus generator
  logic [23:0]   shade = '0;

  function automatic logic [CW-1:0] span(logic [CW-1:0] a, logic [CW-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic int clip(int v, int top);
    return (v < 0) ? 0 : (v > top) ? top : v;
  endfunction

  function automatic int sq8(logic [7:0] a, logic [7:0] b);
    int d;
    d = int'(a) - int'(b);
    return d * d;
  endfunction

  // Work out the result of one accepted request and advance the model state
  task automatic step_line_walk(input scan_req_t q);
    scan_res_t     r;
    logic [CW-1:0] a0, b0, a1, b1, t, cx, cy;
    int            rgb_dist, yh, xh;
    r = '0;
    if (q.kind == KIND_START) begin
      steep = span(q.ey, q.sy) > span(q.ex, q.sx);
      if (steep) begin
        a0 = q.sy; b0 = q.sx; a1 = q.ey; b1 = q.ex;
      end else begin
        a0 = q.sx; b0 = q.sy; a1 = q.ex; b1 = q.ey;
      end
      if (a0 > a1) begin
        t = a0; a0 = a1; a1 = t;
        t = b0; b0 = b1; b1 = t;
      end
      d_maj = a1 - a0;
      d_min = span(b1, b0);
      err = int'(d_maj) / 2;
      minr_down = !(b0 < b1);
      maj = a0;
      maj_end = a1;
      minr = b0;
      gap_len = (q.gap == 8'd0) ? 8'd1 : q.gap;
      skip_left = '0;
      seen_prev = 1'b0;
      on_line = maj < maj_end;
    end else if (on_line) begin
      cx = steep ? minr : maj;
      cy = steep ? maj : minr;
      if (seen_prev && skip_left == 0) begin
        rgb_dist = sq8(q.red, prev_rgb[23:16]) + sq8(q.green, prev_rgb[15:8])
                 + sq8(q.blue, prev_rgb[7:0]);
        if (rgb_dist > int'(cfg_thresh)) begin
          yh = 2 * int'(cfg_height) - 1 - int'(prev_y) - int'(cy);
          xh = int'(prev_x) + int'(cx) + 1;
          r.feat = 1'b1;
          r.fxh = (CW+1)'(clip(xh, HALF_TOP));
          r.fyh = (CW+1)'(clip(yh, HALF_TOP));
          skip_left = gap_len;
        end
      end
      if (skip_left != 0)
        skip_left = skip_left - 8'd1;
      err = err - int'(d_min);
      if (err < 0) begin
        minr = minr_down ? minr - CW'(1) : minr + CW'(1);
        err = err + int'(d_maj);
      end
      maj = maj + CW'(1);
      seen_prev = 1'b1;
      prev_rgb = {q.red, q.green, q.blue};
      prev_x = cx;
      prev_y = cy;
      if (maj >= maj_end)
        on_line = 1'b0;
    end
    // address of the next fetch, or done
    if (on_line) begin
      r.nx = steep ? minr : maj;
      r.ny = steep ? maj : minr;
    end else begin
      r.done = 1'b1;
    end
    due_results = {due_results, r};
  endtask

  // Request driver
  always @(posedge clk) begin : drive
    scan_req_t cur;
    if (rst) begin
      item_valid <= 1'b0;
    end else begin
      if (item_valid && !item_stall)
        step_line_walk({kind, start_x, start_y, end_x, end_y, gap_after_feature,
                        red, green, blue});
      if (!item_valid || !item_stall) begin
        if (pending_reqs.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
          cur = pending_reqs.pop_front();
          item_valid <= 1'b1;
          kind <= cur.kind;
          start_x <= cur.sx;
          start_y <= cur.sy;
          end_x <= cur.ex;
          end_y <= cur.ey;
          gap_after_feature <= cur.gap;
          red <= cur.red;
          green <= cur.green;
          blue <= cur.blue;
        end else begin
          item_valid <= 1'b0;
        end
      end
    end
  end

  task automatic match_field(input string field, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      $display("%0t: %s expected %0d got %0d", $time, field, want, got);
      faults++;
    end
  endtask

  // Result monitor and receiver stall
  always @(posedge clk) begin : watch
    scan_res_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (due_results.size() == 0) begin
          $display("%0t: result with none expected, expected nothing got x=%0d y=%0d",
                   $time, next_x, next_y);
          faults++;
        end else begin
          want = due_results.pop_front();
          match_field("next_x", want.nx, next_x);
          match_field("next_y", want.ny, next_y);
          match_field("line_done", want.done, line_done);
          match_field("feature_found", want.feat, feature_found);
          match_field("feature_x_half", want.fxh, feature_x_half);
          match_field("feature_y_half", want.fyh, feature_y_half);
        end
      end
      result_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  task automatic queue_start(input int sx, input int sy, input int ex, input int ey,
                             input int gap);
    scan_req_t q;
    q = {KIND_START, CW'(sx), CW'(sy), CW'(ex), CW'(ey), 8'(gap),
         8'($urandom), 8'($urandom), 8'($urandom)};
    pending_reqs = {pending_reqs, q};
  endtask

  task automatic queue_pixel(input logic [23:0] rgb);
    scan_req_t q;
    q = {KIND_PIXEL, CW'($urandom), CW'($urandom), CW'($urandom), CW'($urandom),
         8'($urandom), rgb[23:16], rgb[15:8], rgb[7:0]};
    pending_reqs = {pending_reqs, q};
  endtask

  // Pixel colours: drifting near the last one, random, or saturated channels
  function automatic logic [23:0] next_color();
    int unsigned mode;
    mode = $urandom_range(0, 9);
    for (int c = 0; c < 3; c++) begin
      if (mode < 4)
        shade[c*8 +: 8] = 8'(clip(int'(shade[c*8 +: 8]) + $urandom_range(0, 16) - 8, 255));
      else if (mode < 7)
        shade[c*8 +: 8] = 8'($urandom_range(0, 255));
      else
        shade[c*8 +: 8] = $urandom_range(0, 1) ? 8'hFF : 8'h00;
    end
    return shade;
  endfunction

  // Mostly complete lines with random content; some cut short, some noise
  task automatic fill_random(input int unsigned budget);
    int unsigned made, cut, len, n;
    int          sx, sy, ex, ey, major, minor, dxs, dys, gap;
    bit          tall;
    made = 0;
    while (made < budget) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 4);
      if ($urandom_range(0, 99) < 80) begin
        major = ($urandom_range(0, 49) == 0) ? $urandom_range(25, 200)
                                             : $urandom_range(0, 24);
        minor = $urandom_range(0, major);
        tall = $urandom_range(0, 1);
        dxs = tall ? minor : major;
        dys = tall ? major : minor;
        sx = $urandom_range(0, 4095);
        sy = $urandom_range(0, 4095);
        ex = clip($urandom_range(0, 1) ? sx + dxs : sx - dxs, 4095);
        ey = clip($urandom_range(0, 1) ? sy + dys : sy - dys, 4095);
        len = (ex > sx ? ex - sx : sx - ex);
        n = (ey > sy ? ey - sy : sy - ey);
        if (n > len)
          len = n;
        cut = ($urandom_range(0, 99) < 15) ? $urandom_range(0, len) : len;
        queue_start(sx, sy, ex, ey, gap);
        for (int i = 0; i < cut; i++)
          queue_pixel(next_color());
        // stray pixels after the end of the line
        if (cut == len && $urandom_range(0, 9) == 0)
          for (int i = 0; i < $urandom_range(1, 2); i++)
            queue_pixel(next_color());
        made += 1 + cut;
      end else begin
        queue_start($urandom_range(0, 4095), $urandom_range(0, 4095),
                    $urandom_range(0, 4095), $urandom_range(0, 4095), gap);
        n = $urandom_range(0, 3);
        for (int i = 0; i < n; i++)
          queue_pixel(next_color());
        made += 1 + n;
      end
    end
  endtask

  task automatic put_reg(input cfg_reg_t idx, input int unsigned v);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_WIDTH'(v);
    if (idx == REG_IMAGE_HEIGHT)
      cfg_height = 13'(v);
    else
      cfg_thresh = 18'(v);
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Wait until every request is taken and every result has come back
  task automatic drain();
    do
      @(negedge clk);
    while (pending_reqs.size() != 0 || item_valid || due_results.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    int unsigned ph_h[5];
    int unsigned ph_t[5];
    ph_h = '{1, 4096, 8191, 0, 480};
    ph_t = '{0, 195075, 195074, 0, 10000};
    ph_h[3] = $urandom_range(1, 4096);
    ph_t[3] = $urandom_range(0, 195075);
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: pixel with no line, degenerate line and a pixel after it
    queue_pixel(24'hFFFFFF);
    queue_start(5, 7, 5, 7, 3);
    queue_pixel(24'h000000);
    // shallow line with zero gap, alternating black and white
    queue_start(0, 0, 4, 2, 0);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    // steep falling line, endpoints swapped
    queue_start(10, 4095, 8, 4090, 2);
    queue_pixel(24'hFF0000);
    queue_pixel(24'h00FF00);
    queue_pixel(24'h0000FF);
    queue_pixel(24'hFF0000);
    queue_pixel(24'h00FF00);
    // restart mid-line, then a bottom row line where flipped y goes below zero
    queue_start(4095, 0, 4092, 0, 1);
    queue_pixel(24'h123456);
    queue_start(0, 4095, 3, 4095, 255);
    queue_pixel(24'hFFFFFF);
    queue_pixel(24'h000000);
    queue_pixel(24'hFFFFFF);
    queue_start(4095, 4095, 4095, 4095, 255);
    drain();

    // Random phases, one setting of both registers each
    for (int p = 0; p < 5; p++) begin
      put_reg(REG_IMAGE_HEIGHT, ph_h[p]);
      put_reg(REG_DISTANCE_THRESHOLD, ph_t[p]);
      calm = (p == 3);
      fill_random(100);
      drain();
    end

    if (faults == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("testbench: FAIL");
    $finish;
  end

endmodule
